[rtl/dqd_pkg.sv]
// ----------------------------------------------------------------------------
// dqd_pkg: shared definitions for the bounded deque with delete
// sizes, command and status codes, control/status bundles and slot arithmetic
// ----------------------------------------------------------------------------
package dqd_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the item channels
  localparam int CMD_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  // stored word width: value_in is masked to DATA_WIDTH bits
  localparam int DATA_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    push_back;
    logic    push_front;
    logic    pop_back;
    logic    pop_front;
    logic    start_scan;
    logic    step;
    logic    mark_hole;
    logic    write_hole;
    logic    drop_entry;
    logic    status_we;
    status_t status;
    logic    emit;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_code_t op;
    logic      full;
    logic      empty;
    logic      hit;
    logic      more;
    logic      out_free;
  } dp_stat_t;

  // physical slot of logical position pos, counted from base
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] s);
    logic [PTR_W-1:0] r;
    if (s == PTR_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] s);
    logic [PTR_W-1:0] r;
    if (s == '0) begin
      r = PTR_W'(CAPACITY - 1);
    end else begin
      r = s - 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/dqd_in_if.sv]
// ----------------------------------------------------------------------------
// dqd_in_if: command channel
// valid/ready handshake carrying one command item
// ----------------------------------------------------------------------------
interface dqd_in_if import dqd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value_in;

  modport source(output valid, output cmd, output value_in, input ready);
  modport sink(input valid, input cmd, input value_in, output ready);
endinterface

[rtl/dqd_out_if.sv]
// ----------------------------------------------------------------------------
// dqd_out_if: result channel
// valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface dqd_out_if import dqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   value_out;
  logic [STATUS_W-1:0]  status;
  logic [ENTRIES_W-1:0] entries_now;

  modport source(output valid, output value_out, output status, output entries_now,
                 input ready);
  modport sink(input valid, input value_out, input status, input entries_now,
               output ready);
endinterface

[rtl/dqd_datapath.sv]
// ----------------------------------------------------------------------------
// dqd_datapath: entry store, pointers and result register
// circular store with one write and one registered read port per cycle
// ----------------------------------------------------------------------------
module dqd_datapath import dqd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             ctl,
  output dp_stat_t             stat,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [VALUE_W-1:0]   value_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   value_out,
  output logic [STATUS_W-1:0]  status,
  output logic [ENTRIES_W-1:0] entries_now
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  logic [PTR_W-1:0]  front;
  logic [CNT_W-1:0]  total;
  logic [PTR_W-1:0]  cur_slot;
  logic [CNT_W-1:0]  idx;
  logic [PTR_W-1:0]  hole;
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  status_t           status_q;
  logic              pop_ok;

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;

  // memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_of(front, total);
    wr_data = value_q;
    if (ctl.push_back) begin
      wr_en = 1'b1;
    end else if (ctl.push_front) begin
      wr_en   = 1'b1;
      wr_addr = wrap_dec(front);
    end else if (ctl.write_hole) begin
      wr_en   = 1'b1;
      wr_addr = hole;
      wr_data = rd_data;
    end

    rd_en   = ctl.pop_back | ctl.pop_front | ctl.start_scan | ctl.step;
    rd_addr = front;
    if (ctl.pop_back) begin
      rd_addr = slot_of(front, total - 1'b1);
    end else if (ctl.step) begin
      rd_addr = wrap_inc(cur_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      total <= '0;
    end else begin
      if (ctl.push_front) begin
        front <= wrap_dec(front);
      end else if (ctl.pop_front) begin
        front <= wrap_inc(front);
      end
      if (ctl.push_back || ctl.push_front) begin
        total <= total + 1'b1;
      end else if (ctl.pop_back || ctl.pop_front || ctl.drop_entry) begin
        total <= total - 1'b1;
      end
    end
  end

  // item registers and scan cursor
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q    <= cmd;
      value_q  <= DATA_W'(value_in);
      status_q <= ST_OK;
      pop_ok   <= 1'b0;
    end else begin
      if (ctl.status_we) begin
        status_q <= ctl.status;
      end
      if (ctl.pop_back || ctl.pop_front) begin
        pop_ok <= 1'b1;
      end
    end
    if (ctl.start_scan) begin
      idx      <= '0;
      cur_slot <= front;
    end else if (ctl.step) begin
      idx      <= idx + 1'b1;
      cur_slot <= wrap_inc(cur_slot);
    end
    if (ctl.mark_hole || ctl.write_hole) begin
      hole <= cur_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      value_out   <= pop_ok ? VALUE_W'(rd_data) : '0;
      status      <= status_q;
      entries_now <= ENTRIES_W'(total);
    end
  end

  assign stat.op       = cmd_code_t'(cmd_q);
  assign stat.full     = (total == CNT_W'(CAPACITY));
  assign stat.empty    = (total == '0);
  assign stat.hit      = (rd_data == value_q);
  assign stat.more     = ((idx + 1'b1) < total);
  assign stat.out_free = !out_valid || out_ready;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && status_q == ST_FULL |-> stat.full)
    else $error("full reported on a queue with room");

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && status_q == ST_EMPTY |-> stat.empty)
    else $error("empty reported on a non-empty queue");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> idx < total)
    else $error("scan cursor ran past the last entry");

endmodule

[rtl/dqd_ctrl.sv]
// ----------------------------------------------------------------------------
// dqd_ctrl: command sequencer
// one-hot state machine driving the datapath through decode, scan and shift
// ----------------------------------------------------------------------------
module dqd_ctrl import dqd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (stat.op)
          CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (stat.full) begin
              ctl.status_we = 1'b1;
              ctl.status    = ST_FULL;
            end else if (stat.op == CMD_PUSH_BACK) begin
              ctl.push_back = 1'b1;
            end else begin
              ctl.push_front = 1'b1;
            end
          end
          CMD_POP_BACK, CMD_POP_FRONT: begin
            if (stat.empty) begin
              ctl.status_we = 1'b1;
              ctl.status    = ST_EMPTY;
            end else if (stat.op == CMD_POP_BACK) begin
              ctl.pop_back = 1'b1;
            end else begin
              ctl.pop_front = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (stat.empty) begin
              ctl.status_we = 1'b1;
              ctl.status    = ST_NOT_FOUND;
            end else begin
              ctl.start_scan = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          ctl.mark_hole = 1'b1;
          if (stat.more) begin
            ctl.step   = 1'b1;
            state_next = S_SHIFT;
          end else begin
            ctl.drop_entry = 1'b1;
            state_next     = S_DONE;
          end
        end else if (stat.more) begin
          ctl.step = 1'b1;
        end else begin
          ctl.status_we = 1'b1;
          ctl.status    = ST_NOT_FOUND;
          state_next    = S_DONE;
        end
      end
      S_SHIFT: begin
        ctl.write_hole = 1'b1;
        if (stat.more) begin
          ctl.step = 1'b1;
        end else begin
          ctl.drop_entry = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/bounded_deque_with_delete_unit.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_unit: bounded double-ended queue with delete
// push/pop at either end, delete of the first matching word from the front
// push and pop pass through the exec and done states; delete also scans the
// stored entries and shifts later ones; the result is registered once the
// result channel is free; a new item is taken only when idle; the single read
// port of the entry store handles one position per cycle during a delete
// reset: synchronous, clears pointers, count and handshake state;
// the entry store is not cleared, so no extra reset pass is needed
// ----------------------------------------------------------------------------
module bounded_deque_with_delete_unit import dqd_pkg::*; (
  input  logic clk,
  input  logic rst,
  dqd_in_if.sink    req,
  dqd_out_if.source rsp
);

  // command and status bundles between sequencer and datapath
  ctl_cmd_t ctl;
  dp_stat_t stat;
  logic     in_ready;

  // the sequencer takes a new item only when idle; a finished result sits
  // in the datapath's result register, so the next item can be accepted
  // while the previous result still waits for the sink
  dqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  assign req.ready = in_ready;

  // datapath: circular store addressed from the front pointer, delete scans
  // from the front one entry a cycle, then moves later entries into the gap
  dqd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (req.cmd),
    .value_in    (req.value_in),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .value_out   (rsp.value_out),
    .status      (rsp.status),
    .entries_now (rsp.entries_now)
  );

endmodule
